// File: sv/assert_macros.svh
// Assertion macros for the ring buffer delimiter search; used by its top level.
// Needs clk and rst in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RBDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RBDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rbds_pkg.sv
// Package for the ring buffer delimiter search: sizes, codes, types, helpers.
// No dependencies; every other file of the block but assert_macros.svh uses it.
package rbds_pkg;

  // Store depth must be a power of two: positions wrap by truncation.
  localparam int STORE_DEPTH = 512;
  localparam int PATTERN_MAX = 8;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int MATCH_W   = 9;
  localparam int FILL_W    = 10;
  localparam int PAT_W     = 64;
  localparam int CFG_LEN_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [PAT_W-1:0]     PAT_RESET = 64'h0000_0000_0000_0A0D;
  localparam logic [CFG_LEN_W-1:0] LEN_RESET = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_FIND  = 2'd1,
    OP_DROP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 1'd0,
    REG_PATTERN_LENGTH = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              en;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] data;
  } win_ctl_t;

  // Bytes held for given positions and full flag.
  function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] wp,
                                            input logic [AW-1:0] rp,
                                            input logic          full);
    logic [AW-1:0] d;
    d = wp - rp;
    return full ? CW'(STORE_DEPTH) : CW'(d);
  endfunction

  // Pattern length as used in matching: capped at PATTERN_MAX.
  function automatic logic [LW-1:0] used_len(input logic [CFG_LEN_W-1:0] cfg_len);
    if (32'(cfg_len) > PATTERN_MAX) begin
      return LW'(PATTERN_MAX);
    end
    return LW'(cfg_len);
  endfunction

endpackage

// File: sv/rbds_if.sv
// Channel interfaces of the ring buffer delimiter search: command, result, config.
// Depends on rbds_pkg for field widths.
interface rbds_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rbds_pkg::OP_W-1:0]    operation;
  logic [rbds_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface rbds_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [rbds_pkg::MATCH_W-1:0] match_index;
  logic [rbds_pkg::FILL_W-1:0]  fill_count;
  logic                         is_empty;
  logic                         is_full;
  logic                         overwrote;

  modport source (output valid, found, match_index, fill_count, is_empty, is_full,
                  overwrote, input ready);
  modport sink   (input valid, found, match_index, fill_count, is_empty, is_full,
                  overwrote, output ready);
endinterface

interface rbds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbds_pkg::CFG_IDX_W-1:0] index;
  logic [rbds_pkg::PAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/rbds_ram.sv
// Byte store: one write port, one read port with registered read data.
// Depends on rbds_pkg for depth and port structs.
module rbds_ram (
  input  logic                        clk,
  input  rbds_pkg::ram_wr_t           wr,
  input  rbds_pkg::ram_rd_t           rd,
  output logic [rbds_pkg::BYTE_W-1:0] rd_data
);

  logic [rbds_pkg::BYTE_W-1:0] mem [rbds_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: sv/rbds_match.sv
// Match window: the last PATTERN_MAX bytes of a walk, compared against the pattern.
// Depends on rbds_pkg for sizes and the window control struct.
module rbds_match (
  input  logic                        clk,
  input  rbds_pkg::win_ctl_t          ctl,
  input  logic [rbds_pkg::PAT_W-1:0]  pattern,
  input  logic [rbds_pkg::LW-1:0]     len,
  output logic                        all_match
);

  // win[0] holds the newest byte.
  logic [rbds_pkg::BYTE_W-1:0] win [rbds_pkg::PATTERN_MAX];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win[0] <= ctl.data;
      for (int i = 1; i < rbds_pkg::PATTERN_MAX; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // The newest byte lines up with pattern byte len-1.
  always_comb begin
    logic [rbds_pkg::PIW-1:0] pidx;
    pidx      = '0;
    all_match = 1'b1;
    for (int i = 0; i < rbds_pkg::PATTERN_MAX; i++) begin
      if (rbds_pkg::LW'(i) < len) begin
        pidx = rbds_pkg::PIW'(len - rbds_pkg::LW'(1) - rbds_pkg::LW'(i));
        if (win[i] != pattern[rbds_pkg::BYTE_W*pidx +: rbds_pkg::BYTE_W]) begin
          all_match = 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/ring_buffer_delimiter_search_top.sv
// Ring buffer delimiter search, top level. Depends on rbds_pkg, rbds_if, rbds_ram,
// rbds_match and assert_macros.svh.
// Push and clear: one beat per cycle while idle and the output is free; the result
// is registered in the cycle after the beat. Find and drop: a walk reads one held
// byte per cycle through the single RAM read port until the first match or the last
// byte; a pattern that is empty or longer than the held bytes needs no walk.
// Reset (rst, synchronous): positions and full flag zero, pattern CR LF, length 2.
module ring_buffer_delimiter_search_top (
  input logic         clk,
  input logic         rst,
  rbds_cfg_if.sink    cfg,
  rbds_cmd_if.sink    cmd,
  rbds_rsp_if.source  rsp
);

  `include "assert_macros.svh"

  localparam int AW = rbds_pkg::AW;
  localparam int CW = rbds_pkg::CW;
  localparam int LW = rbds_pkg::LW;

  // Ring state: write position, read position, full flag.
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] rp, rp_next;
  logic          full, full_next;

  // Configuration registers.
  logic [rbds_pkg::PAT_W-1:0]     pat;
  logic [rbds_pkg::CFG_LEN_W-1:0] plen;

  rbds_pkg::state_t state, state_next;

  // Walk bookkeeping.
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] iss;         // reads issued
  logic [CW-1:0] rcv;         // bytes shifted into the window
  logic [CW-1:0] walk_fill;
  logic [LW-1:0] walk_len;
  logic          walk_drop;
  logic          rd_valid;    // RAM read data is valid this cycle
  logic          win_new;     // window took a byte at the last edge
  logic          res_found;
  logic [CW-1:0] res_k;       // match offset from the oldest byte

  // Output register.
  logic                         out_valid;
  logic                         out_found;
  logic [rbds_pkg::MATCH_W-1:0] out_index;
  logic [rbds_pkg::FILL_W-1:0]  out_fill;
  logic                         out_empty;
  logic                         out_full;
  logic                         out_over;

  // Decode.
  logic                         out_free;
  logic                         acc;
  rbds_pkg::op_t                op;
  logic                         is_search;
  logic [CW-1:0]                fill_now;
  logic [LW-1:0]                len_now;
  logic                         early_miss;
  logic                         walk_start;
  logic                         issue;
  logic                         hit;
  logic                         all_match;
  logic                         walk_done;

  // Per-state outputs.
  logic                         load_out;
  logic                         o_found;
  logic [AW-1:0]                o_index;
  logic                         o_over;
  logic [CW-1:0]                fill_after;

  rbds_pkg::ram_wr_t            ram_wr;
  rbds_pkg::ram_rd_t            ram_rd;
  logic [rbds_pkg::BYTE_W-1:0]  rd_data;
  rbds_pkg::win_ctl_t           win_ctl;

  // Always taken; the user must send config writes only while idle (not enforced).
  assign cfg.ready = 1'b1;

  // Take a new beat only when idle and the output register frees up this cycle.
  assign out_free   = !out_valid || rsp.ready;
  assign cmd.ready  = (state == rbds_pkg::ST_IDLE) && out_free;
  assign acc        = cmd.valid && cmd.ready;
  assign op         = rbds_pkg::op_t'(cmd.operation);
  assign is_search  = (op == rbds_pkg::OP_FIND) || (op == rbds_pkg::OP_DROP);
  assign fill_now   = rbds_pkg::fill_of(wp, rp, full);
  assign len_now    = rbds_pkg::used_len(plen);
  // Zero length or a pattern longer than the held bytes cannot match.
  assign early_miss = (len_now == '0) || (CW'(len_now) > fill_now);
  assign walk_start = acc && is_search && !early_miss;

  // Issue reads oldest first until every held byte is requested or the walk ends.
  assign issue     = (state == rbds_pkg::ST_WALK) && (iss < walk_fill);
  // Check the window once per new byte; stop on the first match or the last byte.
  assign hit       = win_new && (rcv >= CW'(walk_len)) && all_match;
  assign walk_done = (state == rbds_pkg::ST_WALK) && win_new && (hit || rcv == walk_fill);

  assign ram_rd  = '{en: issue, addr: rd_addr};
  assign win_ctl = '{shift: rd_valid, data: rd_data};

  rbds_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  rbds_match u_match (
    .clk       (clk),
    .ctl       (win_ctl),
    .pattern   (pat),
    .len       (walk_len),
    .all_match (all_match)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rbds_pkg::ST_IDLE: begin
        if (walk_start) state_next = rbds_pkg::ST_WALK;
      end
      rbds_pkg::ST_WALK: begin
        if (walk_done) state_next = rbds_pkg::ST_FINISH;
      end
      rbds_pkg::ST_FINISH: begin
        if (out_free) state_next = rbds_pkg::ST_IDLE;
      end
      default: state_next = rbds_pkg::ST_IDLE;
    endcase
  end

  // Per-state outputs: ring updates, RAM write, result load.
  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    full_next = full;
    load_out  = 1'b0;
    o_found   = 1'b0;
    o_index   = '0;
    o_over    = 1'b0;
    ram_wr    = '{en: 1'b0, addr: wp, data: cmd.data_byte};
    unique case (state)
      rbds_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (op)
            rbds_pkg::OP_PUSH: begin
              load_out  = 1'b1;
              ram_wr.en = 1'b1;
              wp_next   = wp + AW'(1);
              if (full) begin
                // Overwrite the oldest byte: read position follows.
                o_over  = 1'b1;
                rp_next = wp + AW'(1);
              end else if (wp + AW'(1) == rp) begin
                full_next = 1'b1;
              end
            end
            rbds_pkg::OP_FIND, rbds_pkg::OP_DROP: begin
              load_out = early_miss;
            end
            rbds_pkg::OP_CLEAR: begin
              load_out  = 1'b1;
              wp_next   = '0;
              rp_next   = '0;
              full_next = 1'b0;
            end
          endcase
        end
      end
      rbds_pkg::ST_WALK: begin
      end
      rbds_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          o_found  = res_found;
          if (res_found) begin
            o_index = rp + AW'(res_k);
          end
          // A drop that found the pattern discards through its last byte.
          if (res_found && walk_drop) begin
            rp_next   = rp + AW'(res_k + CW'(walk_len));
            full_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign fill_after = rbds_pkg::fill_of(wp_next, rp_next, full_next);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbds_pkg::ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      full      <= 1'b0;
      pat       <= rbds_pkg::PAT_RESET;
      plen      <= rbds_pkg::LEN_RESET;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      win_new   <= 1'b0;
    end else begin
      state    <= state_next;
      wp       <= wp_next;
      rp       <= rp_next;
      full     <= full_next;
      rd_valid <= issue;
      win_new  <= (state == rbds_pkg::ST_WALK) && rd_valid;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (rbds_pkg::reg_idx_t'(cfg.index))
          rbds_pkg::REG_PATTERN_BYTES:  pat  <= cfg.data;
          rbds_pkg::REG_PATTERN_LENGTH: plen <= cfg.data[rbds_pkg::CFG_LEN_W-1:0];
        endcase
      end
    end
  end

  // Walk counters and result payload.
  always_ff @(posedge clk) begin
    if (walk_start) begin
      rd_addr   <= rp;
      iss       <= '0;
      rcv       <= '0;
      walk_fill <= fill_now;
      walk_len  <= len_now;
      walk_drop <= (op == rbds_pkg::OP_DROP);
    end else begin
      if (issue) begin
        rd_addr <= rd_addr + AW'(1);
        iss     <= iss + CW'(1);
      end
      if (rd_valid) begin
        rcv <= rcv + CW'(1);
      end
    end
    if (walk_done) begin
      res_found <= hit;
      res_k     <= rcv - CW'(walk_len);
    end
    if (load_out) begin
      out_found <= o_found;
      out_index <= rbds_pkg::MATCH_W'(o_index);
      out_fill  <= rbds_pkg::FILL_W'(fill_after);
      out_empty <= (fill_after == '0);
      out_full  <= full_next;
      out_over  <= o_over;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.match_index = out_index;
  assign rsp.fill_count  = out_fill;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;
  assign rsp.overwrote   = out_over;

  // Assertions.
  `RBDS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == rbds_pkg::ST_IDLE && !out_valid), "not idle after reset")
  `RBDS_ASSERT(a_full_pos, full |-> (wp == rp), "full flag set with positions apart")
  `RBDS_ASSERT(a_walk_bounds, (state == rbds_pkg::ST_WALK) |-> (iss <= walk_fill && rcv <= iss), "walk counters out of range")
  `RBDS_ASSERT(a_rd_in_walk, rd_valid |-> $past(state == rbds_pkg::ST_WALK), "read data outside a walk")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_buffer_delimiter_search_top: a directed table, then
// randomized push/find/drop/clear traffic scored against an in-bench ring model.
// Depends on rbds_pkg and the cfg/cmd/rsp channel interfaces of rbds_if.
module tb_top;

  // Allow for the slowest legal run (full-store walks, long stalls) with margin
  // before calling it a hang.
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PRINT_CAP   = 200;

  typedef struct packed {
    logic                         found;
    logic [rbds_pkg::MATCH_W-1:0] match_index;
    logic [rbds_pkg::FILL_W-1:0]  fill_count;
    logic                         is_empty;
    logic                         is_full;
    logic                         overwrote;
  } ring_status_t;

  // Per-beat note from the driver: a hand-written status overrides the model.
  typedef struct packed {
    logic         pinned;
    ring_status_t status;
  } pin_t;

  typedef struct packed {
    rbds_pkg::op_t               op;
    logic [rbds_pkg::BYTE_W-1:0] data;
    logic                        pinned;
    ring_status_t                status;
  } dir_row_t;

  localparam ring_status_t EMPTY_STATUS = '{1'b0, 9'd0, 10'd0, 1'b1, 1'b0, 1'b0};

  logic clk;
  logic rst;

  rbds_cfg_if cfg();
  rbds_cmd_if cmd();
  rbds_rsp_if rsp();

  ring_buffer_delimiter_search_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .rsp (rsp)
  );

  // Ring model, owned by the scoreboard process below.
  logic [rbds_pkg::BYTE_W-1:0]    ring_mem [rbds_pkg::STORE_DEPTH];
  logic [rbds_pkg::AW-1:0]        wr_ptr;
  logic [rbds_pkg::AW-1:0]        rd_ptr;
  logic                           ring_full;
  logic [rbds_pkg::PAT_W-1:0]     delim;
  logic [rbds_pkg::CFG_LEN_W-1:0] delim_len;

  ring_status_t status_q [$];  // statuses still owed by the block, oldest first
  pin_t         pin_q [$];     // driver notes for beats offered but not yet taken

  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned hold_requests  = 0;

  // Stimulus-side copy of the delimiter, so byte picking never races the model.
  logic                           gaps_on;
  logic [rbds_pkg::PAT_W-1:0]     stim_delim;
  logic [rbds_pkg::CFG_LEN_W-1:0] stim_len;

  dir_row_t dir_table [18];

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------

  function automatic int unsigned ring_fill();
    logic [rbds_pkg::AW-1:0] span;
    span = wr_ptr - rd_ptr;
    return ring_full ? rbds_pkg::STORE_DEPTH : int'(span);
  endfunction

  // Lengths above the pattern width behave as the full width.
  function automatic int unsigned delim_used();
    return (delim_len > rbds_pkg::PATTERN_MAX) ? rbds_pkg::PATTERN_MAX : int'(delim_len);
  endfunction

  // Scan held bytes oldest first, across the wrap; off is distance from rd_ptr.
  function automatic logic locate_delim(output int unsigned off);
    int unsigned n;
    int unsigned fill;
    int unsigned k;
    int unsigned m;
    logic        hit;
    n    = delim_used();
    fill = ring_fill();
    off  = 0;
    if (n == 0 || n > fill) begin
      return 1'b0;
    end
    for (k = 0; k + n <= fill; k++) begin
      hit = 1'b1;
      for (m = 0; m < n; m++) begin
        if (ring_mem[rbds_pkg::AW'(rd_ptr + k + m)] != delim[8*m +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        off = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one operation to the ring model and return the status it reports.
  function automatic ring_status_t ring_status_after(input rbds_pkg::op_t op,
                                                     input logic [rbds_pkg::BYTE_W-1:0] b);
    ring_status_t st;
    int unsigned  off;
    int unsigned  fill;
    st = '0;
    case (op)
      rbds_pkg::OP_PUSH: begin
        ring_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (ring_full) begin
          // Full store: oldest byte lost, tail rides along with head.
          st.overwrote = 1'b1;
          rd_ptr = wr_ptr;
        end else if (wr_ptr == rd_ptr) begin
          ring_full = 1'b1;
        end
      end
      rbds_pkg::OP_FIND, rbds_pkg::OP_DROP: begin
        if (locate_delim(off)) begin
          st.found       = 1'b1;
          st.match_index = rbds_pkg::MATCH_W'(rbds_pkg::AW'(rd_ptr + off));
          if (op == rbds_pkg::OP_DROP) begin
            rd_ptr    = rbds_pkg::AW'(rd_ptr + off + delim_used());
            ring_full = 1'b0;
          end
        end
      end
      default: begin
        wr_ptr    = '0;
        rd_ptr    = '0;
        ring_full = 1'b0;
      end
    endcase
    fill          = ring_fill();
    st.fill_count = rbds_pkg::FILL_W'(fill);
    st.is_empty   = (fill == 0);
    st.is_full    = ring_full;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0d ns: mismatch, %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got_v,
                             input int unsigned want_v);
    if (got_v != want_v) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                result_count, name, got_v, want_v));
    end
  endtask

  // Sample all three channels at the edge; every driver uses nonblocking updates,
  // so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    ring_status_t got;
    ring_status_t want;
    pin_t         pin;
    if (rst) begin
      wr_ptr    = '0;
      rd_ptr    = '0;
      ring_full = 1'b0;
      delim     = rbds_pkg::PAT_RESET;
      delim_len = rbds_pkg::LEN_RESET;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.found, rsp.match_index, rsp.fill_count, rsp.is_empty, rsp.is_full,
                rsp.overwrote};
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: beat with nothing outstanding",
                                    result_count));
        end else begin
          want = status_q.pop_front();
          check_field("found", got.found, want.found);
          check_field("match_index", got.match_index, want.match_index);
          check_field("fill_count", got.fill_count, want.fill_count);
          check_field("is_empty", got.is_empty, want.is_empty);
          check_field("is_full", got.is_full, want.is_full);
          check_field("overwrote", got.overwrote, want.overwrote);
        end
        result_count++;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == rbds_pkg::REG_PATTERN_BYTES) begin
          delim = cfg.data;
        end else begin
          delim_len = cfg.data[rbds_pkg::CFG_LEN_W-1:0];
        end
      end
      if (cmd.valid && cmd.ready) begin
        // Always advance the model; a pinned row only replaces what is expected.
        pin  = pin_q.pop_front();
        want = ring_status_after(rbds_pkg::op_t'(cmd.operation), cmd.data_byte);
        status_q.push_back(pin.pinned ? pin.status : want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Receiver: free-running stall pattern in windows of random length, plus a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    hold_left   = 0;
    hold_served = 0;
    mode        = 0;
    mode_left   = 0;
    tick        = 0;
    rsp.ready   = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 3) != 0);
          default: rsp.ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one command beat and hold it until taken. Bursts of random length are
  // separated by random gaps when gaps are enabled.
  task automatic send_item(input rbds_pkg::op_t op, input logic [rbds_pkg::BYTE_W-1:0] b,
                           input logic pinned, input ring_status_t status);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pin_q.push_back('{pinned, status});
    cmd.valid     <= 1'b1;
    cmd.operation <= op;
    cmd.data_byte <= b;
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  task automatic send_op(input rbds_pkg::op_t op);
    send_item(op, 8'($urandom), 1'b0, '0);
  endtask

  // Drop valid and wait until every outstanding status has come back.
  task automatic settle();
    cmd.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (status_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it once its last write is through.
  task automatic write_reg(input rbds_pkg::reg_idx_t idx,
                           input logic [rbds_pkg::PAT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  function automatic int unsigned stim_used();
    return (stim_len > rbds_pkg::PATTERN_MAX) ? rbds_pkg::PATTERN_MAX : int'(stim_len);
  endfunction

  // Bias toward delimiter bytes so partial and overlapping matches turn up.
  function automatic logic [rbds_pkg::BYTE_W-1:0] pick_byte();
    int unsigned i;
    i = $urandom_range(0, rbds_pkg::PATTERN_MAX - 1);
    return ($urandom_range(0, 9) < 4) ? stim_delim[8*i +: 8] : 8'($urandom);
  endfunction

  task automatic push_delim();
    int unsigned i;
    for (i = 0; i < stim_used(); i++) begin
      send_item(rbds_pkg::OP_PUSH, stim_delim[8*i +: 8], 1'b0, '0);
    end
  endtask

  task automatic push_run(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_delim();
      end else begin
        send_item(rbds_pkg::OP_PUSH, pick_byte(), 1'b0, '0);
      end
    end
  endtask

  // One random sequence: mostly well-formed records holding the delimiter, else
  // broken records, raw noise or the odd clear.
  task automatic run_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    int unsigned i;
    n    = stim_used();
    pick = $urandom_range(0, 39);
    if (pick == 0) begin
      send_op(rbds_pkg::OP_CLEAR);
    end else if (pick < 4) begin
      repeat ($urandom_range(1, 6)) send_item(rbds_pkg::op_t'($urandom_range(0, 3)),
                                              8'($urandom), 1'b0, '0);
    end else if (pick < 10) begin
      // Truncated delimiter, sometimes followed by a corrupted next byte.
      push_run($urandom_range(0, 6));
      k = (n == 0) ? 0 : $urandom_range(0, n - 1);
      for (i = 0; i < k; i++) begin
        send_item(rbds_pkg::OP_PUSH, stim_delim[8*i +: 8], 1'b0, '0);
      end
      if ($urandom_range(0, 1) == 1) begin
        send_item(rbds_pkg::OP_PUSH, stim_delim[8*k +: 8] ^ 8'($urandom_range(1, 255)),
                  1'b0, '0);
      end
      send_op(($urandom_range(0, 1) == 1) ? rbds_pkg::OP_FIND : rbds_pkg::OP_DROP);
    end else begin
      push_run($urandom_range(0, 10));
      push_delim();
      push_run($urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0: send_op(rbds_pkg::OP_FIND);
        1: send_op(rbds_pkg::OP_DROP);
        2: begin
          send_op(rbds_pkg::OP_FIND);
          send_op(rbds_pkg::OP_DROP);
        end
        default: begin
          send_op(rbds_pkg::OP_DROP);
          send_op(rbds_pkg::OP_FIND);
        end
      endcase
    end
  endtask

  // Reprogram the delimiter while idle, then run random traffic. fill_up first
  // drives the store past full (overwrite, wrap, search and drop on a full store).
  // pressure 1 asks the receiver for a long hold-off midway; pressure 2 makes the
  // sender wait out every outstanding status midway.
  task automatic run_phase(input logic [rbds_pkg::PAT_W-1:0] pat,
                           input logic [rbds_pkg::CFG_LEN_W-1:0] len,
                           input int unsigned count, input logic gaps, input logic fill_up,
                           input int unsigned pressure);
    int unsigned phase_end;
    logic        pressed;
    settle();
    write_reg(rbds_pkg::REG_PATTERN_BYTES, pat);
    write_reg(rbds_pkg::REG_PATTERN_LENGTH, rbds_pkg::PAT_W'(len));
    cfg.valid <= 1'b0;
    stim_delim = pat;
    stim_len   = len;
    gaps_on    = gaps;
    phase_end  = items_sent + count;
    pressed    = 1'b0;
    if (fill_up) begin
      send_op(rbds_pkg::OP_CLEAR);
      repeat (rbds_pkg::STORE_DEPTH + 20) send_item(rbds_pkg::OP_PUSH, pick_byte(), 1'b0, '0);
      send_op(rbds_pkg::OP_FIND);
      send_op(rbds_pkg::OP_DROP);
      send_op(rbds_pkg::OP_FIND);
      push_run(40);
      send_op(rbds_pkg::OP_FIND);
    end
    while (items_sent < phase_end) begin
      if (!pressed && items_sent > phase_end - count / 2) begin
        pressed = 1'b1;
        if (pressure == 1) begin
          hold_requests <= hold_requests + 1;
        end else if (pressure == 2) begin
          settle();
        end
      end
      run_sequence();
    end
  endtask

  initial begin
    int unsigned r;
    rst           = 1'b1;
    cmd.valid     = 1'b0;
    cmd.operation = rbds_pkg::OP_PUSH;
    cmd.data_byte = '0;
    cfg.valid     = 1'b0;
    cfg.index     = rbds_pkg::REG_PATTERN_BYTES;
    cfg.data      = '0;
    gaps_on       = 1'b1;
    stim_delim    = rbds_pkg::PAT_RESET;
    stim_len      = rbds_pkg::LEN_RESET;

    // Reset delimiter is CR LF. Pinned rows are read straight off the behavior;
    // the rest go through the model.
    dir_table = '{
      '{rbds_pkg::OP_FIND,  8'h00, 1'b1, EMPTY_STATUS},                    // empty store
      '{rbds_pkg::OP_DROP,  8'hFF, 1'b1, EMPTY_STATUS},
      '{rbds_pkg::OP_CLEAR, 8'h00, 1'b1, EMPTY_STATUS},
      '{rbds_pkg::OP_PUSH,  8'h00, 1'b1, '{1'b0, 9'd0, 10'd1, 1'b0, 1'b0, 1'b0}},
      '{rbds_pkg::OP_PUSH,  8'hFF, 1'b1, '{1'b0, 9'd0, 10'd2, 1'b0, 1'b0, 1'b0}},
      '{rbds_pkg::OP_PUSH,  8'h0D, 1'b1, '{1'b0, 9'd0, 10'd3, 1'b0, 1'b0, 1'b0}},
      '{rbds_pkg::OP_PUSH,  8'h0A, 1'b1, '{1'b0, 9'd0, 10'd4, 1'b0, 1'b0, 1'b0}},
      // CR LF at slot 2
      '{rbds_pkg::OP_FIND,  8'hFF, 1'b1, '{1'b1, 9'd2, 10'd4, 1'b0, 1'b0, 1'b0}},
      '{rbds_pkg::OP_PUSH,  8'h0D, 1'b1, '{1'b0, 9'd0, 10'd5, 1'b0, 1'b0, 1'b0}},
      // lone CR left
      '{rbds_pkg::OP_DROP,  8'h00, 1'b1, '{1'b1, 9'd2, 10'd1, 1'b0, 1'b0, 1'b0}},
      // pattern longer than what is held
      '{rbds_pkg::OP_FIND,  8'h00, 1'b1, '{1'b0, 9'd0, 10'd1, 1'b0, 1'b0, 1'b0}},
      // failed drop
      '{rbds_pkg::OP_DROP,  8'h00, 1'b1, '{1'b0, 9'd0, 10'd1, 1'b0, 1'b0, 1'b0}},
      '{rbds_pkg::OP_PUSH,  8'h0A, 1'b0, '0},
      '{rbds_pkg::OP_DROP,  8'h55, 1'b0, '0},
      '{rbds_pkg::OP_PUSH,  8'hAA, 1'b0, '0},
      '{rbds_pkg::OP_PUSH,  8'h55, 1'b0, '0},
      '{rbds_pkg::OP_FIND,  8'h00, 1'b0, '0},
      '{rbds_pkg::OP_CLEAR, 8'hAA, 1'b1, EMPTY_STATUS}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < $size(dir_table); r++) begin
      send_item(dir_table[r].op, dir_table[r].data, dir_table[r].pinned,
                dir_table[r].status);
    end

    run_phase(rbds_pkg::PAT_RESET, rbds_pkg::LEN_RESET, 140, 1'b1, 1'b0, 0);
    run_phase({rbds_pkg::PAT_W{1'b1}}, 4'd1, 130, 1'b1, 1'b0, 0);
    run_phase({$urandom, $urandom}, 4'd8, 600, 1'b1, 1'b1, 0);
    run_phase({rbds_pkg::PAT_W{1'b0}}, 4'd0, 100, 1'b1, 1'b0, 0);  // zero length never matches
    run_phase({$urandom, $urandom}, 4'd15, 130, 1'b1, 1'b0, 1);    // length clamps to eight
    run_phase({$urandom, $urandom}, 4'($urandom_range(1, 7)), 140, 1'b0, 1'b0, 2);
    run_phase({$urandom, $urandom}, 4'd3, 590, 1'b1, 1'b1, 0);

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
